// ----- rtl/rdq_pkg.sv -----
// Shared types for the reversible deque: command codes, controller states,
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rdq_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned CNT_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_QUERY      = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_POP_FRONT  = 3'd4,
		CMD_TOGGLE     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // execute the input word this cycle
		logic rd_en;   // read head and tail entries of the ring
		logic load;    // load the result register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // result register empty or being taken
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rdq_ctrl.sv -----
// Sequencing state machine for the reversible deque.
// Depends on rdq_pkg.
`default_nettype none

module rdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rdq_pkg::dp_stat_t stat,
	output rdq_pkg::ctl_cmd_t ctl
);

	rdq_pkg::state_t state_q;
	rdq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		ctl.accept = 1'b0;
		ctl.rd_en  = 1'b0;
		ctl.load   = 1'b0;
		unique case (state_q)
			rdq_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				ctl.accept = in_valid;
				if (in_valid) begin
					state_d = rdq_pkg::ST_READ;
				end
			end
			rdq_pkg::ST_READ: begin
				ctl.rd_en = 1'b1;
				state_d   = rdq_pkg::ST_LOAD;
			end
			rdq_pkg::ST_LOAD: begin
				// hold the read data until the result register frees up
				if (stat.out_free) begin
					ctl.load = 1'b1;
					state_d  = rdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rdq_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> state_q == rdq_pkg::ST_READ)
		else $error("accept not followed by read");

	a_read_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |=> state_q == rdq_pkg::ST_LOAD)
		else $error("read not followed by load state");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> stat.out_free)
		else $error("result loaded while register busy");
`endif

endmodule

`default_nettype wire

// ----- rtl/rdq_datapath.sv -----
// Ring store, pointers, reverse flag and result register of the deque.
// Depends on rdq_pkg; driven by rdq_ctrl.
`default_nettype none

module rdq_datapath #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rdq_pkg::ctl_cmd_t                     ctl,
	output rdq_pkg::dp_stat_t                     stat,
	input  logic [rdq_pkg::CMD_W-1:0]             command,
	input  logic signed [rdq_pkg::WORD_W-1:0]     value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [rdq_pkg::WORD_W-1:0]     front_value,
	output logic signed [rdq_pkg::WORD_W-1:0]     back_value,
	output logic [rdq_pkg::CNT_W-1:0]             count,
	output logic                                  error
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned OW = $clog2(DEPTH + 1);
	localparam int unsigned SW = OW + 1;

	logic [rdq_pkg::WORD_W-1:0] ring_mem [DEPTH];

	logic [AW-1:0] head_q;
	logic [OW-1:0] occ_q;
	logic          rev_q;
	logic          err_q;

	logic [rdq_pkg::WORD_W-1:0] rd_head_q;
	logic [rdq_pkg::WORD_W-1:0] rd_tail_q;

	logic                              out_valid_q;
	logic [rdq_pkg::WORD_W-1:0]        front_q;
	logic [rdq_pkg::WORD_W-1:0]        back_q;
	logic [rdq_pkg::CNT_W-1:0]         count_q;
	logic                              error_q;

	rdq_pkg::cmd_t cmd;
	logic          is_push;
	logic          is_pop;
	logic          at_head;
	logic          full;
	logic          empty;
	logic          ok;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [SW-1:0] end_sum;
	logic [AW-1:0] end_idx;
	logic [SW-1:0] tail_sum;
	logic [AW-1:0] tail_idx;

	assign cmd   = rdq_pkg::cmd_t'(command);
	assign full  = (occ_q == OW'(DEPTH));
	assign empty = (occ_q == '0);

	always_comb begin
		is_push = (cmd == rdq_pkg::CMD_PUSH_BACK) || (cmd == rdq_pkg::CMD_PUSH_FRONT);
		is_pop  = (cmd == rdq_pkg::CMD_POP_BACK) || (cmd == rdq_pkg::CMD_POP_FRONT);
		// reverse flag swaps which physical end a front/back command touches
		at_head = ((cmd == rdq_pkg::CMD_PUSH_FRONT) || (cmd == rdq_pkg::CMD_POP_FRONT)) ^ rev_q;
		if (is_push) begin
			ok = !full;
		end else if (is_pop) begin
			ok = !empty;
		end else begin
			ok = 1'b1;
		end
	end

	// modular pointer arithmetic, DEPTH need not be a power of two
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		end_sum = SW'(head_q) + SW'(occ_q);
		if (end_sum >= SW'(DEPTH)) begin
			end_idx = AW'(end_sum - SW'(DEPTH));
		end else begin
			end_idx = AW'(end_sum);
		end
		tail_sum = end_sum - SW'(1);
		if (empty) begin
			tail_idx = head_q;
		end else if (tail_sum >= SW'(DEPTH)) begin
			tail_idx = AW'(tail_sum - SW'(DEPTH));
		end else begin
			tail_idx = AW'(tail_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
			rev_q  <= 1'b0;
		end else if (ctl.accept) begin
			if (cmd == rdq_pkg::CMD_TOGGLE) begin
				rev_q <= ~rev_q;
			end
			if (ok && is_push) begin
				occ_q <= occ_q + OW'(1);
				if (at_head) begin
					head_q <= head_dec;
				end
			end
			if (ok && is_pop) begin
				occ_q <= occ_q - OW'(1);
				if (at_head) begin
					head_q <= head_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			err_q <= !ok;
		end
	end

	// ring store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (ctl.accept && ok && is_push) begin
			ring_mem[at_head ? head_dec : end_idx] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_head_q <= ring_mem[head_q];
			rd_tail_q <= ring_mem[tail_idx];
		end
	end

	// result register
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (empty) begin
				front_q <= '1;
				back_q  <= '1;
			end else begin
				front_q <= rev_q ? rd_tail_q : rd_head_q;
				back_q  <= rev_q ? rd_head_q : rd_tail_q;
			end
			count_q <= rdq_pkg::CNT_W'(occ_q);
			error_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign front_value = front_q;
	assign back_value  = back_q;
	assign count       = count_q;
	assign error       = error_q;

`ifndef SYNTHESIS
	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("occupancy above depth");

	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(DEPTH - 1))
		else $error("head pointer out of range");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.load))
		else $error("result valid without load");
`endif

endmodule

`default_nettype wire

// ----- rtl/reversible_deque.sv -----
// Reversible deque: ring of DEPTH signed words with an O(1) reverse flag.
// The accepting edge executes the command, the ring read registers both
// ends, and the result register is loaded once it is free. A new command
// waits (in_stall) until the last one has passed its result load.
// Reset clears head pointer, count, reverse flag and control; the ring
// contents are not cleared and only occupied entries ever reach the result.
`default_nettype none

module reversible_deque #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rdq_pkg::CMD_W-1:0]         command,
	input  logic signed [rdq_pkg::WORD_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rdq_pkg::WORD_W-1:0] front_value,
	output logic signed [rdq_pkg::WORD_W-1:0] back_value,
	output logic [rdq_pkg::CNT_W-1:0]         count,
	output logic                              error
);

	rdq_pkg::ctl_cmd_t ctl;
	rdq_pkg::dp_stat_t stat;

	rdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	rdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count),
		.error       (error)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_reversible_deque.sv -----
// Testbench for reversible_deque: drives commands with random gaps and output stalls,
// predicts each status word with a shadow deque and compares every result field.
// Depends on rdq_pkg and the reversible_deque RTL.

module tb_reversible_deque;

	localparam int RING_DEPTH = 16;
	// codes with no operation of their own; the block treats them as a query
	localparam logic [rdq_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [rdq_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

	typedef struct packed {
		logic signed [rdq_pkg::WORD_W-1:0] front;
		logic signed [rdq_pkg::WORD_W-1:0] back;
		logic [rdq_pkg::CNT_W-1:0]         cnt;
		logic                              err;
	} deque_status_t;

	logic                              clk;
	logic                              arst_n    = 1'b0;
	logic                              in_valid  = 1'b0;
	logic                              in_stall;
	logic [rdq_pkg::CMD_W-1:0]         command   = rdq_pkg::CMD_QUERY;
	logic signed [rdq_pkg::WORD_W-1:0] value     = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [rdq_pkg::WORD_W-1:0] front_value;
	logic signed [rdq_pkg::WORD_W-1:0] back_value;
	logic [rdq_pkg::CNT_W-1:0]         count;
	logic                              error;

	// shadow copy of the deque
	logic [rdq_pkg::WORD_W-1:0] shadow_ring [RING_DEPTH];
	logic [3:0]                 shadow_head = '0;
	logic [rdq_pkg::CNT_W-1:0]  shadow_count = '0;
	logic                       shadow_rev = 1'b0;

	deque_status_t pending_status [$];

	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int hold_off_cycles = 0;
	int words_sent = 0;
	int results_checked = 0;
	int rejected = 0;
	int toggles = 0;
	int peak_fill = 0;
	int mismatches = 0;

	reversible_deque #(.DEPTH(RING_DEPTH)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count),
		.error       (error)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic head_push(logic [rdq_pkg::WORD_W-1:0] w);
		if (shadow_count == RING_DEPTH) return 1'b0;
		shadow_head = shadow_head - 4'd1;
		shadow_ring[shadow_head] = w;
		shadow_count = shadow_count + 5'd1;
		return 1'b1;
	endfunction

	function automatic logic tail_push(logic [rdq_pkg::WORD_W-1:0] w);
		if (shadow_count == RING_DEPTH) return 1'b0;
		shadow_ring[shadow_head + shadow_count[3:0]] = w;
		shadow_count = shadow_count + 5'd1;
		return 1'b1;
	endfunction

	function automatic logic head_pop();
		if (shadow_count == 0) return 1'b0;
		shadow_head = shadow_head + 4'd1;
		shadow_count = shadow_count - 5'd1;
		return 1'b1;
	endfunction

	function automatic logic tail_pop();
		if (shadow_count == 0) return 1'b0;
		shadow_count = shadow_count - 5'd1;
		return 1'b1;
	endfunction

	function automatic deque_status_t apply_command(logic [rdq_pkg::CMD_W-1:0] cmd,
			logic [rdq_pkg::WORD_W-1:0] w);
		deque_status_t st;
		logic ok;
		logic [3:0] tail;
		ok = 1'b1;
		case (cmd)
			rdq_pkg::CMD_PUSH_BACK: begin
				if (shadow_rev) ok = head_push(w);
				else ok = tail_push(w);
			end
			rdq_pkg::CMD_PUSH_FRONT: begin
				if (shadow_rev) ok = tail_push(w);
				else ok = head_push(w);
			end
			rdq_pkg::CMD_POP_BACK: begin
				if (shadow_rev) ok = head_pop();
				else ok = tail_pop();
			end
			rdq_pkg::CMD_POP_FRONT: begin
				if (shadow_rev) ok = tail_pop();
				else ok = head_pop();
			end
			rdq_pkg::CMD_TOGGLE: shadow_rev = ~shadow_rev;
			default: ;
		endcase
		// at full count the low 4 bits wrap to 0, so tail lands on head - 1
		tail = shadow_head + shadow_count[3:0] - 4'd1;
		if (shadow_count == 0) begin
			// -1 on both ends when empty
			st.front = '1;
			st.back  = '1;
		end else begin
			st.front = shadow_rev ? shadow_ring[tail] : shadow_ring[shadow_head];
			st.back  = shadow_rev ? shadow_ring[shadow_head] : shadow_ring[tail];
		end
		st.cnt = shadow_count;
		st.err = ~ok;
		return st;
	endfunction

	// mostly short, a few long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [rdq_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [rdq_pkg::CMD_W-1:0] pick_command(int unsigned push_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2) return $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
		if (r < 6) return rdq_pkg::CMD_QUERY;
		if (r < 14) return rdq_pkg::CMD_TOGGLE;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? rdq_pkg::CMD_PUSH_BACK : rdq_pkg::CMD_PUSH_FRONT;
		return $urandom_range(0, 1) ? rdq_pkg::CMD_POP_BACK : rdq_pkg::CMD_POP_FRONT;
	endfunction

	// entered and left just after a rising edge
	task automatic send_word(input logic [rdq_pkg::CMD_W-1:0] cmd,
			input logic [rdq_pkg::WORD_W-1:0] w);
		int gap;
		deque_status_t st;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		st = apply_command(cmd, w);
		pending_status.push_back(st);
		words_sent++;
		if (st.err) rejected++;
		if (cmd == rdq_pkg::CMD_TOGGLE) toggles++;
		if (shadow_count > peak_fill) peak_fill = shadow_count;
	endtask

	task automatic test_directed_ends();
		send_word(rdq_pkg::CMD_QUERY, 32'h1234_5678);
		send_word(rdq_pkg::CMD_POP_BACK, '0);
		send_word(rdq_pkg::CMD_POP_FRONT, '0);
		send_word(rdq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
		send_word(rdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
		send_word(rdq_pkg::CMD_TOGGLE, '1);
		send_word(rdq_pkg::CMD_QUERY, '0);
		send_word(rdq_pkg::CMD_POP_FRONT, '0);
		send_word(rdq_pkg::CMD_PUSH_BACK, '0);
		send_word(CMD_RSVD6, '1);
		send_word(CMD_RSVD7, 32'h5555_AAAA);
		send_word(rdq_pkg::CMD_TOGGLE, '0);
		send_word(rdq_pkg::CMD_POP_BACK, '0);
		send_word(rdq_pkg::CMD_POP_BACK, '0);
		send_word(rdq_pkg::CMD_POP_FRONT, '0);
	endtask

	task automatic test_fill_and_drain();
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (i == RING_DEPTH / 2) send_word(rdq_pkg::CMD_TOGGLE, '0);
			send_word(i[0] ? rdq_pkg::CMD_PUSH_BACK : rdq_pkg::CMD_PUSH_FRONT, pick_word());
		end
		send_word(rdq_pkg::CMD_PUSH_BACK, pick_word());
		send_word(rdq_pkg::CMD_PUSH_FRONT, pick_word());
		send_word(rdq_pkg::CMD_TOGGLE, '0);
		send_word(rdq_pkg::CMD_QUERY, '0);
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (i == RING_DEPTH / 2) send_word(rdq_pkg::CMD_TOGGLE, '0);
			send_word(i[0] ? rdq_pkg::CMD_POP_FRONT : rdq_pkg::CMD_POP_BACK, '0);
		end
		send_word(rdq_pkg::CMD_POP_FRONT, '0);
	endtask

	// receiver holds off while words keep coming, so the block backs up
	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		hold_off_cycles = 64;
		for (int i = 0; i < 24; i++)
			send_word(i < 16 ? pick_command(100) : pick_command(0), pick_word());
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic(input int n_words);
		int unsigned push_bias [8] = '{80, 50, 20, 95, 60, 5, 50, 70};
		for (int p = 0; p < 8; p++) begin
			gaps_on   = (p % 3) != 0;
			stalls_on = (p % 4) != 1;
			for (int i = 0; i < n_words / 8; i++)
				send_word(pick_command(push_bias[p]), pick_word());
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	initial begin : out_side
		int stall_run;
		stall_run = 0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				out_stall <= 1'b1;
			end else if (stall_run > 0) begin
				stall_run--;
				out_stall <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 3) == 0) begin
				stall_run = pick_gap();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		deque_status_t exp;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing expected", results_checked);
			end else begin
				exp = pending_status.pop_front();
				if (front_value !== exp.front || back_value !== exp.back ||
						count !== exp.cnt || error !== exp.err) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d: exp front=%0d back=%0d count=%0d error=%0b",
							results_checked, exp.front, exp.back, exp.cnt, exp.err);
						$display("  got front=%0d back=%0d count=%0d error=%0b",
							front_value, back_value, count, error);
					end
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_ends();
		test_fill_and_drain();
		test_output_backpressure();
		test_random_traffic(880);
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d commands, %0d status words checked, %0d mismatches",
			words_sent, results_checked, mismatches);
		$display("%0d rejected push/pop, %0d reversals, peak fill %0d of %0d",
			rejected, toggles, peak_fill, RING_DEPTH);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
